// ===== hw/rtl/bpc_pkg.sv =====
package bpc_pkg;

	// Register map of the configuration port
	typedef enum logic [2:0] {
		REG_T1    = 3'd0,
		REG_T2    = 3'd1,
		REG_T3    = 3'd2,
		REG_P1    = 3'd3,
		REG_P2_P3 = 3'd4,
		REG_P4_P5 = 3'd5,
		REG_P6_P7 = 3'd6,
		REG_P8_P9 = 3'd7
	} cfg_idx_t;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned RAW_W = 20;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned WIDE_W = 64;
	// divisor magnitude never exceeds 2^30 after the 33-bit arithmetic shift
	localparam int unsigned DVS_W = WIDE_W - 33;

	localparam logic [32:0] FINE_OFS = 33'd128000;
	localparam logic [20:0] PRESS_OFS = 21'd1048576;
	localparam logic [63:0] NUM_SCALE = 64'd3125;
	localparam logic [31:0] TC_ROUND = 32'd128;
	localparam logic [63:0] DVS_BIAS = 64'd1 << 47;

	typedef struct packed {
		logic        [15:0] t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic        [15:0] p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
	} cfg_t;

	// Fields that ride alongside the division
	typedef struct packed {
		logic        neg;
		logic        dz;
		logic [31:0] tc;
		logic [31:0] fine;
	} side_t;

	typedef struct packed {
		logic             valid;
		logic [63:0]      ua;
		logic [DVS_W-1:0] ub;
		side_t            side;
	} div_in_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] uq;
		side_t       side;
	} div_out_t;

endpackage

// ===== hw/rtl/bpc_cfg.sv =====
module bpc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bpc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output bpc_pkg::cfg_t                    cfg
);

	logic [15:0] t1_q, t2_q, t3_q, p1_q;
	logic [31:0] p23_q, p45_q, p67_q, p89_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t1_q  <= '0;
			t2_q  <= '0;
			t3_q  <= '0;
			p1_q  <= '0;
			p23_q <= '0;
			p45_q <= '0;
			p67_q <= '0;
			p89_q <= '0;
		end else if (cfg_we) begin
			unique case (bpc_pkg::cfg_idx_t'(cfg_index))
				bpc_pkg::REG_T1:    t1_q  <= cfg_data[15:0];
				bpc_pkg::REG_T2:    t2_q  <= cfg_data[15:0];
				bpc_pkg::REG_T3:    t3_q  <= cfg_data[15:0];
				bpc_pkg::REG_P1:    p1_q  <= cfg_data[15:0];
				bpc_pkg::REG_P2_P3: p23_q <= cfg_data;
				bpc_pkg::REG_P4_P5: p45_q <= cfg_data;
				bpc_pkg::REG_P6_P7: p67_q <= cfg_data;
				bpc_pkg::REG_P8_P9: p89_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.t1 = t1_q;
		cfg.t2 = t2_q;
		cfg.t3 = t3_q;
		cfg.p1 = p1_q;
		cfg.p2 = p23_q[15:0];
		cfg.p3 = p23_q[31:16];
		cfg.p4 = p45_q[15:0];
		cfg.p5 = p45_q[31:16];
		cfg.p6 = p67_q[15:0];
		cfg.p7 = p67_q[31:16];
		cfg.p8 = p89_q[15:0];
		cfg.p9 = p89_q[31:16];
	end

endmodule

// ===== hw/rtl/bpc_front.sv =====
module bpc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [bpc_pkg::RAW_W-1:0]     raw_temperature,
	input  logic [bpc_pkg::RAW_W-1:0]     raw_pressure,
	input  bpc_pkg::cfg_t                 cfg,
	output bpc_pkg::div_in_t              div_in
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;

	logic [31:0] m1_s1, m2_s1;
	logic [19:0] rp_s1, rp_s2, rp_s3, rp_s4, rp_s5, rp_s6;
	logic [31:0] a_s2, m3_s2;
	logic [31:0] fine_s3;
	logic [31:0] fine_s4, fine_s5, fine_s6, fine_s7, fine_s8, fine_s9;
	logic [31:0] tc_s4, tc_s5, tc_s6, tc_s7, tc_s8, tc_s9;
	logic signed [32:0] v1_s4;
	logic [63:0] sq_s5;
	logic [48:0] pv5_s5, pv2_s5, pv5_s6, pv2_s6;
	logic [63:0] v2a_s6, v1a_s6;
	logic [63:0] v2_s7, v1b_s7;
	logic [20:0] pd_s7;
	logic [63:0] nsub_s8, v1s_s8;
	logic [63:0] num_s9, v1m_s9;
	logic [63:0] ua_s10;
	logic [bpc_pkg::DVS_W-1:0] ub_s10;
	bpc_pkg::side_t side_s10;

	logic [31:0] x_t, d_t, m1, m2, sh12, m3, fine, fine5;
	logic signed [65:0] sq;
	logic signed [79:0] pr6, pr3;
	logic [bpc_pkg::DVS_W-1:0] dvs;

	always_comb begin
		x_t   = 32'(raw_temperature[19:3]) - {15'd0, cfg.t1, 1'b0};
		d_t   = 32'(raw_temperature[19:4]) - 32'(cfg.t1);
		m1    = x_t * 32'(cfg.t2);
		m2    = d_t * d_t;
		sh12  = $signed(m2_s1) >>> 12;
		m3    = sh12 * 32'(cfg.t3);
		fine  = a_s2 + 32'($signed(m3_s2) >>> 14);
		fine5 = (fine_s3 << 2) + fine_s3 + bpc_pkg::TC_ROUND;
		sq    = 66'(v1_s4) * 66'(v1_s4);
		pr6   = 80'($signed(sq_s5)) * 80'(cfg.p6);
		pr3   = 80'($signed(sq_s5)) * 80'(cfg.p3);
		dvs   = v1m_s9[63:33];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10} <= '0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// temperature, 32-bit wrap
			m1_s1   <= m1;
			m2_s1   <= m2;
			rp_s1   <= raw_pressure;
			a_s2    <= 32'($signed(m1_s1) >>> 11);
			m3_s2   <= m3;
			rp_s2   <= rp_s1;
			fine_s3 <= fine;
			rp_s3   <= rp_s2;
			tc_s4   <= 32'($signed(fine5) >>> 8);
			fine_s4 <= fine_s3;
			v1_s4   <= 33'($signed(fine_s3)) - $signed(bpc_pkg::FINE_OFS);
			rp_s4   <= rp_s3;
			// pressure polynomial, 64-bit wrap
			sq_s5   <= sq[63:0];
			pv5_s5  <= 49'(v1_s4) * 49'(cfg.p5);
			pv2_s5  <= 49'(v1_s4) * 49'(cfg.p2);
			tc_s5   <= tc_s4;
			fine_s5 <= fine_s4;
			rp_s5   <= rp_s4;
			v2a_s6  <= pr6[63:0];
			v1a_s6  <= pr3[63:0];
			pv5_s6  <= pv5_s5;
			pv2_s6  <= pv2_s5;
			tc_s6   <= tc_s5;
			fine_s6 <= fine_s5;
			rp_s6   <= rp_s5;
			v2_s7   <= v2a_s6 + (64'($signed(pv5_s6)) << 17) + (64'(cfg.p4) << 35);
			v1b_s7  <= 64'($signed(v1a_s6) >>> 8) + (64'($signed(pv2_s6)) << 12);
			pd_s7   <= bpc_pkg::PRESS_OFS - 21'(rp_s6);
			tc_s7   <= tc_s6;
			fine_s7 <= fine_s6;
			nsub_s8 <= (64'(pd_s7) << 31) - v2_s7;
			v1s_s8  <= v1b_s7 + bpc_pkg::DVS_BIAS;
			tc_s8   <= tc_s7;
			fine_s8 <= fine_s7;
			num_s9  <= nsub_s8 * bpc_pkg::NUM_SCALE;
			v1m_s9  <= v1s_s8 * 64'(cfg.p1);
			tc_s9   <= tc_s8;
			fine_s9 <= fine_s8;
			// split into magnitudes and a quotient sign for the divider
			ua_s10        <= num_s9[63] ? -num_s9 : num_s9;
			ub_s10        <= dvs[bpc_pkg::DVS_W-1] ? -dvs : dvs;
			side_s10.neg  <= num_s9[63] ^ dvs[bpc_pkg::DVS_W-1];
			side_s10.dz   <= (dvs == '0);
			side_s10.tc   <= tc_s9;
			side_s10.fine <= fine_s9;
		end
	end

	always_comb begin
		div_in.valid = v_s10;
		div_in.ua    = ua_s10;
		div_in.ub    = ub_s10;
		div_in.side  = side_s10;
	end

endmodule

// ===== hw/rtl/bpc_div.sv =====
module bpc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  bpc_pkg::div_in_t   div_in,
	output bpc_pkg::div_out_t  div_out
);

	localparam int unsigned N = bpc_pkg::WIDE_W;
	localparam int unsigned RW = bpc_pkg::DVS_W;

	logic                vld_s  [N];
	logic [RW-1:0]       rem_s  [N];
	logic [N-1:0]        dq_s   [N];
	logic [RW-1:0]       ub_s   [N];
	bpc_pkg::side_t      side_s [N];

	// one quotient bit per stage; dividend bits shift out as quotient bits shift in
	for (genvar k = 0; k < N; k++) begin : g_step
		logic                vld_i;
		logic [RW-1:0]       rem_i;
		logic [N-1:0]        dq_i;
		logic [RW-1:0]       ub_i;
		bpc_pkg::side_t      side_i;
		logic [RW:0]         trial;
		logic                ge;

		if (k == 0) begin : g_head
			assign vld_i  = div_in.valid;
			assign rem_i  = '0;
			assign dq_i   = div_in.ua;
			assign ub_i   = div_in.ub;
			assign side_i = div_in.side;
		end else begin : g_body
			assign vld_i  = vld_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign dq_i   = dq_s[k-1];
			assign ub_i   = ub_s[k-1];
			assign side_i = side_s[k-1];
		end

		assign trial = {rem_i, dq_i[N-1]};
		assign ge    = trial >= {1'b0, ub_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? RW'(trial - {1'b0, ub_i}) : trial[RW-1:0];
				dq_s[k]   <= {dq_i[N-2:0], ge};
				ub_s[k]   <= ub_i;
				side_s[k] <= side_i;
			end
		end
	end

	assign div_out.valid = vld_s[N-1];
	assign div_out.uq    = dq_s[N-1];
	assign div_out.side  = side_s[N-1];

endmodule

// ===== hw/rtl/bpc_back.sv =====
module bpc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  bpc_pkg::div_out_t  div_out,
	input  bpc_pkg::cfg_t      cfg,
	output logic               out_valid,
	output logic [31:0]        temperature_centi,
	output logic [31:0]        pressure_q24_8,
	output logic [31:0]        fine_temperature,
	output logic               divisor_zero
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q;
	bpc_pkg::side_t sd_s1, sd_s2, sd_s3, sd_s4, sd_s5;
	logic [63:0] p_s1, p_s2, p_s3, p_s4;
	logic [63:0] ps_s2, m9_s2, m8_s2;
	logic [63:0] ll_s3, v2_s3, v2_s4;
	logic [31:0] lh_s3, hl_s3;
	logic [63:0] prod_s4, sum_s5;
	logic [31:0] tc_q, pres_q, fine_q;
	logic        dz_q;

	logic [63:0] ps;
	logic signed [79:0] pr9, pr8;
	logic [31:0] pres;

	always_comb begin
		ps   = $signed(p_s1) >>> 13;
		pr9  = 80'($signed(ps)) * 80'(cfg.p9);
		pr8  = 80'($signed(p_s1)) * 80'(cfg.p8);
		pres = sum_s5[39:8] + (32'(cfg.p7) << 4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q} <= '0;
		end else if (en) begin
			v_s1        <= div_out.valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= div_out.side.neg ? -div_out.uq : div_out.uq;
			sd_s1   <= div_out.side;
			m9_s2   <= pr9[63:0];
			m8_s2   <= pr8[63:0];
			ps_s2   <= ps;
			p_s2    <= p_s1;
			sd_s2   <= sd_s1;
			// low 64 bits of the square term from 32-bit partial products
			ll_s3   <= 64'(m9_s2[31:0]) * 64'(ps_s2[31:0]);
			lh_s3   <= m9_s2[31:0] * ps_s2[63:32];
			hl_s3   <= m9_s2[63:32] * ps_s2[31:0];
			v2_s3   <= $signed(m8_s2) >>> 19;
			p_s3    <= p_s2;
			sd_s3   <= sd_s2;
			prod_s4 <= ll_s3 + {lh_s3 + hl_s3, 32'd0};
			v2_s4   <= v2_s3;
			p_s4    <= p_s3;
			sd_s4   <= sd_s3;
			sum_s5  <= p_s4 + 64'($signed(prod_s4) >>> 25) + v2_s4;
			sd_s5   <= sd_s4;
			tc_q    <= sd_s5.tc;
			fine_q  <= sd_s5.fine;
			dz_q    <= sd_s5.dz;
			pres_q  <= sd_s5.dz ? '0 : pres;
		end
	end

	assign out_valid         = out_valid_q;
	assign temperature_centi = tc_q;
	assign pressure_q24_8    = pres_q;
	assign fine_temperature  = fine_q;
	assign divisor_zero      = dz_q;

endmodule

// ===== hw/rtl/baro_temp_pressure_compensation.sv =====
// Barometric temperature and pressure compensation.
//
// Input channel (in_valid/in_ready): one word holds a raw 20-bit temperature
// and a raw 20-bit pressure conversion. Output channel (out_valid/out_ready):
// one word holds temperature in 0.01 degC, pressure in Pa as unsigned Q24.8,
// the fine temperature and a flag raised when the pressure divisor is zero
// (pressure then reads 0).
// Calibration sits in eight registers written through cfg_we/cfg_index/
// cfg_data; write them only while the pipeline is empty.
//
// Pipeline from input acceptance to out_valid: ten stages of temperature and
// pressure polynomial, 64 stages of the restoring divider (one quotient bit
// per stage), five stages of the final polynomial and the output register.
// Throughput: one word per cycle while the receiver does not stall.
//
// Reset clears every valid bit and all calibration registers to zero.
// A stalled receiver freezes the whole pipeline in place: in_ready drops in
// the same cycle, and no word is lost or repeated.
module baro_temp_pressure_compensation (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bpc_pkg::RAW_W-1:0]     raw_temperature,
	input  logic [bpc_pkg::RAW_W-1:0]     raw_pressure,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [31:0]                   temperature_centi,
	output logic [31:0]                   pressure_q24_8,
	output logic [31:0]                   fine_temperature,
	output logic                          divisor_zero
);

	bpc_pkg::cfg_t     cfg;
	bpc_pkg::div_in_t  div_in;
	bpc_pkg::div_out_t div_out;
	logic              en;

	// advance every stage together unless the output word is held
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	bpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// temperature, pressure polynomial and divider operands
	bpc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.in_valid        (in_valid),
		.raw_temperature (raw_temperature),
		.raw_pressure    (raw_pressure),
		.cfg             (cfg),
		.div_in          (div_in)
	);

	// signed division done on magnitudes, sign restored afterwards
	bpc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.div_in  (div_in),
		.div_out (div_out)
	);

	bpc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.en                (en),
		.div_out           (div_out),
		.cfg               (cfg),
		.out_valid         (out_valid),
		.temperature_centi (temperature_centi),
		.pressure_q24_8    (pressure_q24_8),
		.fine_temperature  (fine_temperature),
		.divisor_zero      (divisor_zero)
	);

	// zero divisor forces the pressure word to zero
	a_dz_pressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divisor_zero |-> pressure_q24_8 == '0)
		else $error("pressure not cleared on zero divisor");

	// temperature and fine temperature must leave from the same item
	a_tc_matches_fine: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> temperature_centi ==
			32'($signed(fine_temperature * 32'd5 + bpc_pkg::TC_ROUND) >>> 8))
		else $error("temperature word misaligned with fine temperature");

	// the held pressure word and divisor flag stay unchanged while the pipeline is frozen
	a_hold_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pressure_q24_8) && $stable(divisor_zero))
		else $error("pipeline moved while stalled");

endmodule

// ===== verif/bpc_checker.sv =====
`timescale 1ns / 100ps

module bpc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [19:0] raw_temperature,
	input  logic [19:0] raw_pressure,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] temperature_centi,
	input  logic [31:0] pressure_q24_8,
	input  logic [31:0] fine_temperature,
	input  logic        divisor_zero,
	output int          fail_count,
	output int          pending_count
);

	typedef struct packed {
		logic [31:0] tc;
		logic [31:0] pres;
		logic [31:0] fine;
		logic        dz;
	} comp_t;

	logic [31:0] coef [8];
	comp_t       comp_q [$];

	function automatic logic signed [63:0] sx64(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic comp_t compensate(input logic [19:0] adc_t, input logic [19:0] adc_p);
		comp_t r;
		logic signed [31:0] t1, t2, t3, a, d, fine;
		logic signed [63:0] v1, v2, p, ps, p1, num, q;
		logic [63:0] ua, ub;
		t1 = {16'd0, coef[bpc_pkg::REG_T1][15:0]};
		t2 = {{16{coef[bpc_pkg::REG_T2][15]}}, coef[bpc_pkg::REG_T2][15:0]};
		t3 = {{16{coef[bpc_pkg::REG_T3][15]}}, coef[bpc_pkg::REG_T3][15:0]};
		a = $signed((({12'd0, adc_t} >> 3) - (t1 <<< 1)) * t2) >>> 11;
		d = {16'd0, adc_t[19:4]} - t1;
		d = (((d * d) >>> 12) * t3) >>> 14;
		fine = a + d;
		r.fine = fine;
		r.tc = (fine * 5 + 128) >>> 8;
		r.dz = 1'b0;
		r.pres = '0;
		p1 = {48'd0, coef[bpc_pkg::REG_P1][15:0]};
		v1 = {{32{fine[31]}}, fine} - 64'sd128000;
		v2 = v1 * v1 * sx64(coef[bpc_pkg::REG_P6_P7][15:0]);
		v2 = v2 + ((v1 * sx64(coef[bpc_pkg::REG_P4_P5][31:16])) <<< 17);
		v2 = v2 + (sx64(coef[bpc_pkg::REG_P4_P5][15:0]) <<< 35);
		v1 = ((v1 * v1 * sx64(coef[bpc_pkg::REG_P2_P3][31:16])) >>> 8)
			+ ((v1 * sx64(coef[bpc_pkg::REG_P2_P3][15:0])) <<< 12);
		v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
		if (v1 == 0) begin
			r.dz = 1'b1;
		end else begin
			p = 64'sd1048576 - {44'd0, adc_p};
			num = ((p <<< 31) - v2) * 64'sd3125;
			// divide on magnitudes so the most negative value wraps cleanly
			ua = num[63] ? -num : num;
			ub = v1[63] ? -v1 : v1;
			q = ua / ub;
			p = (num[63] != v1[63]) ? -q : q;
			ps = p >>> 13;
			v1 = (sx64(coef[bpc_pkg::REG_P8_P9][31:16]) * ps * ps) >>> 25;
			v2 = (sx64(coef[bpc_pkg::REG_P8_P9][15:0]) * p) >>> 19;
			p = ((p + v1 + v2) >>> 8) + (sx64(coef[bpc_pkg::REG_P6_P7][31:16]) <<< 4);
			r.pres = p[31:0];
		end
		return r;
	endfunction

	assign pending_count = comp_q.size();

	always @(posedge clk or negedge arst_n) begin
		comp_t e;
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) coef[i] <= '0;
			comp_q.delete();
			fail_count <= 0;
		end else begin
			if (cfg_we) begin
				coef[cfg_index] <= (cfg_index < bpc_pkg::REG_P2_P3)
					? {16'd0, cfg_data[15:0]} : cfg_data;
			end
			if (in_valid && in_ready) begin
				comp_q.push_back(compensate(raw_temperature, raw_pressure));
			end
			if (out_valid && out_ready) begin
				if (comp_q.size() == 0) begin
					$display("%0t: unexpected word tc=%h p=%h f=%h dz=%b", $time,
						temperature_centi, pressure_q24_8, fine_temperature, divisor_zero);
					fail_count <= fail_count + 1;
				end else begin
					e = comp_q.pop_front();
					if (e.tc !== temperature_centi || e.pres !== pressure_q24_8
						|| e.fine !== fine_temperature || e.dz !== divisor_zero) begin
						$display("%0t: mismatch expected tc=%h p=%h f=%h dz=%b %s",
							$time, e.tc, e.pres, e.fine, e.dz, "actual");
						$display("%0t: actual tc=%h p=%h f=%h dz=%b", $time,
							temperature_centi, pressure_q24_8, fine_temperature,
							divisor_zero);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

	localparam int LATENCY = 80;
	localparam int CYCLE_LIMIT = 1000000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	bpc_pkg::cfg_idx_t    cfg_index;
	logic [31:0]          cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [19:0]          raw_temperature;
	logic [19:0]          raw_pressure;
	logic                 out_valid;
	logic                 out_ready;
	logic [31:0]          temperature_centi;
	logic [31:0]          pressure_q24_8;
	logic [31:0]          fine_temperature;
	logic                 divisor_zero;
	int                   fail_count;
	int                   pending_count;
	int                   cycle_count;

	baro_temp_pressure_compensation i_dut (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .raw_temperature, .raw_pressure,
		.out_valid, .out_ready, .temperature_centi, .pressure_q24_8,
		.fine_temperature, .divisor_zero
	);

	bpc_checker i_checker (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .raw_temperature, .raw_pressure,
		.out_valid, .out_ready, .temperature_centi, .pressure_q24_8,
		.fine_temperature, .divisor_zero, .fail_count, .pending_count
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Receiver stalls at random, with stretches of no stalling
	initial begin
		int n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			n = gap_len();
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	// Watchdog: give up at a generous limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Drive one word and hold it until accepted
	task automatic send_word(input logic [19:0] t, input logic [19:0] p);
		in_valid        <= 1'b1;
		raw_temperature <= t;
		raw_pressure    <= p;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_gap();
		int n;
		n = gap_len();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Drain the pipeline, then let the latency pass so it is truly empty
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_coef(input bpc_pkg::cfg_idx_t idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Plausible sensor calibration with random jitter
	task automatic load_typical();
		write_coef(bpc_pkg::REG_T1, 16'd27504 + $urandom_range(0, 2000) - 1000);
		write_coef(bpc_pkg::REG_T2, 16'd26435 + $urandom_range(0, 200) - 100);
		write_coef(bpc_pkg::REG_T3, 16'hFC18 + $urandom_range(0, 200));
		write_coef(bpc_pkg::REG_P1, 16'd36477 + $urandom_range(0, 2000) - 1000);
		write_coef(bpc_pkg::REG_P2_P3, {16'd3024, 16'hD4BC});
		write_coef(bpc_pkg::REG_P4_P5, {16'd140, 16'd2855});
		write_coef(bpc_pkg::REG_P6_P7, {16'd15500, 16'hFFF9});
		write_coef(bpc_pkg::REG_P8_P9, {16'd6000, 16'hC0B8});
	endtask

	task automatic load_random();
		write_coef(bpc_pkg::REG_T1, $urandom);
		write_coef(bpc_pkg::REG_T2, $urandom);
		write_coef(bpc_pkg::REG_T3, $urandom);
		write_coef(bpc_pkg::REG_P1, $urandom);
		write_coef(bpc_pkg::REG_P2_P3, $urandom);
		write_coef(bpc_pkg::REG_P4_P5, $urandom);
		write_coef(bpc_pkg::REG_P6_P7, $urandom);
		write_coef(bpc_pkg::REG_P8_P9, $urandom);
	endtask

	task automatic load_all(input logic [31:0] val);
		for (int i = 0; i < 8; i++) write_coef(bpc_pkg::cfg_idx_t'(i), val);
	endtask

	initial begin
		logic [19:0] t, p;
		cycle_count     = 0;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = bpc_pkg::REG_T1;
		cfg_data        = '0;
		in_valid        = 1'b0;
		raw_temperature = '0;
		raw_pressure    = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// All coefficients zero: divisor is zero, flag must rise
		send_word(20'h00000, 20'h00000);
		send_word(20'hFFFFF, 20'hFFFFF);
		drain();

		// Extremes: every coefficient at its top and bottom
		load_all(32'hFFFFFFFF);
		send_word(20'h00000, 20'hFFFFF);
		send_word(20'hFFFFF, 20'h00000);
		send_word(20'h80000, 20'h7FFFF);
		drain();
		load_all(32'h80008000);
		send_word(20'h00000, 20'h00000);
		send_word(20'hFFFFF, 20'hFFFFF);
		drain();
		load_all(32'h7FFF7FFF);
		send_word(20'h55555, 20'hAAAAA);
		send_word(20'hAAAAA, 20'h55555);
		drain();

		// Typical calibration with field extremes
		load_typical();
		send_word(20'd519888, 20'd415148);
		send_word(20'h00000, 20'h00000);
		send_word(20'hFFFFF, 20'hFFFFF);
		send_word(20'hFFFFF, 20'h00000);
		send_word(20'h00000, 20'hFFFFF);
		for (int i = 0; i < 6; i++) send_word(20'($urandom), 20'($urandom));

		// Hold off until every result has come back, then resume
		drain();

		// Random phases: mostly realistic calibration, some wild ones
		for (int ph = 0; ph < 9; ph++) begin
			if (ph % 3 == 2) load_random();
			else load_typical();
			for (int i = 0; i < 200; i++) begin
				if ($urandom_range(0, 3) != 0) begin
					t = 20'(20'd400000 + $urandom_range(0, 300000));
					p = 20'(20'd250000 + $urandom_range(0, 300000));
				end else begin
					t = 20'($urandom);
					p = 20'($urandom);
				end
				send_word(t, p);
				send_gap();
			end
			drain();
		end

		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
